[rtl/bcrt_pkg.sv]
// Shared types, constants and helper functions for the box corner rotate and
// translate unit: port widths, register indexes, fixed-point constants, tables.
// No dependencies.
package bcrt_pkg;

  // port widths
  localparam int S_TDATA_W = 128;  // pos_x, pos_y, pos_z, turn_angle, zero fill
  localparam int S_TUSER_W = 2;    // action
  localparam int M_TDATA_W = 96;   // corner_x, corner_y, corner_z
  localparam int M_TUSER_W = 3;    // corner_index
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CORNER_COUNT = 8;
  localparam int CORNER_W = 3;

  // action codes
  localparam logic [S_TUSER_W-1:0] ACT_REBUILD = 2'd0;
  localparam logic [S_TUSER_W-1:0] ACT_MOVE    = 2'd1;
  localparam logic [S_TUSER_W-1:0] ACT_ROTATE  = 2'd2;
  localparam logic [S_TUSER_W-1:0] ACT_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z   = 3'd5;

  // angle constants, Q9.16 degrees held in 27 bits
  localparam logic signed [26:0] DEG_90  = 27'sd5898240;
  localparam logic signed [26:0] DEG_180 = 27'sd11796480;
  localparam logic signed [26:0] DEG_360 = 27'sd23592960;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] PI_OVER_180_Q32 = 32'sd74961321;
  localparam int ATAN_ENTRIES = 30;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [33:0] cordic_t;

  // atan(2^-i) in radians, Q2.30
  function automatic cordic_t atan_q30(input logic [4:0] idx);
    cordic_t v;
    unique case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      5'd24: v = 34'sd63;
      5'd25: v = 34'sd31;
      5'd26: v = 34'sd15;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // corner signs: bit0 X positive, bit1 Y positive, bit2 Z positive
  function automatic logic [2:0] corner_sign(input logic [CORNER_W-1:0] k);
    logic [2:0] s;
    unique case (k)
      3'd0: s = 3'b000;
      3'd1: s = 3'b010;
      3'd2: s = 3'b011;
      3'd3: s = 3'b001;
      3'd4: s = 3'b100;
      3'd5: s = 3'b110;
      3'd6: s = 3'b111;
      3'd7: s = 3'b101;
      default: s = 3'b000;
    endcase
    return s;
  endfunction

  // clamp a 35-bit signed sum into the signed 32-bit range
  function automatic coord_t sat32(input logic signed [34:0] v);
    coord_t r;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

[rtl/box_corner_rotate_translate_unit.sv]
// Top level of the box corner rotate and translate unit: sequencer, CORDIC,
// shared multiplier, box state and the output register.
// Depends on bcrt_pkg.
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------------
//  s        | s_tvalid s_tready s_tdata s_tuser         | one action beat in
//  m        | m_tvalid m_tready m_tdata m_tuser m_tlast | eight corner beats out
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data    | register writes, always ready
//
// Rebuild and move go from acceptance straight to corner output, one corner a
// cycle while m_tready allows. Rotate steps through angle preparation (wrap,
// fold, magnitude, degree to radian multiply), a load, CORDIC_STEPS CORDIC
// iterations, a sign step, the rotation of each corner on the one shared 32x32
// multiplier and then the output of all eight corners. The shared multiplier
// and the single output register set the pace; a stalled m_tready holds the
// sequencer in its output phase. Reset is synchronous and clears the box to
// zero; there is no clearing pass.
module box_corner_rotate_translate_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata, low bit up: pos_x[31:0], pos_y[63:32], pos_z[95:64],
  // turn_angle[121:96], zero fill[127:122]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bcrt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [bcrt_pkg::S_TUSER_W-1:0]   s_tuser,   // action
  // m_tdata, low bit up: corner_x[31:0], corner_y[63:32], corner_z[95:64]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bcrt_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [bcrt_pkg::M_TUSER_W-1:0]   m_tuser,   // corner_index
  output logic                             m_tlast,   // last_corner
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int CN = bcrt_pkg::CORNER_COUNT;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WRAP   = 4'd1;
  localparam logic [3:0] ST_FOLD   = 4'd2;
  localparam logic [3:0] ST_MAG    = 4'd3;
  localparam logic [3:0] ST_MULZ   = 4'd4;
  localparam logic [3:0] ST_ZLOAD  = 4'd5;
  localparam logic [3:0] ST_CORDIC = 4'd6;
  localparam logic [3:0] ST_SIGN   = 4'd7;
  localparam logic [3:0] ST_ROT    = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;

  // multiplier phases of one corner rotation
  localparam logic [2:0] PH_CX  = 3'd0;  // issue cos*x
  localparam logic [2:0] PH_SY  = 3'd1;  // issue sin*y, take cos*x
  localparam logic [2:0] PH_SX  = 3'd2;  // issue sin*x, form new x
  localparam logic [2:0] PH_CY  = 3'd3;  // issue cos*y, take sin*x
  localparam logic [2:0] PH_WR  = 3'd4;  // form new y, write back

  logic [3:0] state;

  // configuration registers
  logic [30:0]           box_length, box_width, box_height;
  bcrt_pkg::coord_t      start_x, start_y, start_z;

  // box state
  bcrt_pkg::coord_t      cen_x, cen_y, cen_z;
  bcrt_pkg::coord_t      ox [CN];
  bcrt_pkg::coord_t      oy [CN];
  bcrt_pkg::coord_t      oz [CN];

  // angle and CORDIC working registers
  logic signed [26:0]    ang;
  logic                  flip;
  logic                  ang_neg;
  logic [23:0]           ang_mag;
  bcrt_pkg::cordic_t     cx, cy, cz;
  logic [STEP_W-1:0]     step;
  bcrt_pkg::coord_t      sin_q, cos_q;

  // shared multiplier
  bcrt_pkg::coord_t      mul_a, mul_b;
  logic signed [63:0]    prod;
  logic signed [33:0]    prod_sh;

  logic signed [33:0]    acc;
  bcrt_pkg::coord_t      new_x;
  logic [2:0]            phase;
  logic [bcrt_pkg::CORNER_W-1:0] k;

  logic                  out_free;
  logic signed [31:0]    hx, hy, hz;
  bcrt_pkg::cordic_t     dx, dy, z_pos;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // arithmetic shift of the product by 30: Q2.30 times Q16.16 back to Q16.16
  assign prod_sh = prod[63:30];

  assign hx = $signed({2'b00, box_length[30:1]});
  assign hy = $signed({2'b00, box_width[30:1]});
  assign hz = $signed({2'b00, box_height[30:1]});

  // dx turns x by the shifted y, dy turns y by the shifted x
  assign dx    = cy >>> step;
  assign dy    = cx >>> step;
  assign z_pos = $signed({2'b00, prod[49:18]});

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MULZ) begin
      mul_a = $signed({8'b0, ang_mag});
      mul_b = bcrt_pkg::PI_OVER_180_Q32;
    end else if (state == ST_ROT) begin
      case (phase)
        PH_CX: begin
          mul_a = cos_q;
          mul_b = ox[k];
        end
        PH_SY: begin
          mul_a = sin_q;
          mul_b = oy[k];
        end
        PH_SX: begin
          mul_a = sin_q;
          mul_b = ox[k];
        end
        PH_CY: begin
          mul_a = cos_q;
          mul_b = oy[k];
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_length <= '0;
      box_width  <= '0;
      box_height <= '0;
      start_x    <= '0;
      start_y    <= '0;
      start_z    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcrt_pkg::REG_BOX_LENGTH: box_length <= cfg_data[30:0];
        bcrt_pkg::REG_BOX_WIDTH:  box_width  <= cfg_data[30:0];
        bcrt_pkg::REG_BOX_HEIGHT: box_height <= cfg_data[30:0];
        bcrt_pkg::REG_CENTRE_X:   start_x    <= $signed(cfg_data);
        bcrt_pkg::REG_CENTRE_Y:   start_y    <= $signed(cfg_data);
        bcrt_pkg::REG_CENTRE_Z:   start_z    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer and box state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      k        <= '0;
      phase    <= PH_CX;
      step     <= '0;
      cen_x    <= '0;
      cen_y    <= '0;
      cen_z    <= '0;
      for (int i = 0; i < CN; i++) begin
        ox[i] <= '0;
        oy[i] <= '0;
        oz[i] <= '0;
      end
    end else begin
      // load a beat whenever the output register frees up, drop it once taken
      if ((state == ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          k     <= '0;
          phase <= PH_CX;
          if (s_tvalid) begin
            case (s_tuser)
              bcrt_pkg::ACT_REBUILD: begin
                for (int i = 0; i < CN; i++) begin
                  logic [2:0] s;
                  s = bcrt_pkg::corner_sign(i[bcrt_pkg::CORNER_W-1:0]);
                  ox[i] <= s[0] ? hx : -hx;
                  oy[i] <= s[1] ? hy : -hy;
                  oz[i] <= s[2] ? hz : -hz;
                end
                cen_x <= start_x;
                cen_y <= start_y;
                cen_z <= start_z;
                state <= ST_EMIT;
              end
              bcrt_pkg::ACT_MOVE: begin
                cen_x <= $signed(s_tdata[31:0]);
                cen_y <= $signed(s_tdata[63:32]);
                cen_z <= $signed(s_tdata[95:64]);
                state <= ST_EMIT;
              end
              bcrt_pkg::ACT_ROTATE: begin
                ang   <= 27'($signed(s_tdata[121:96]));
                state <= ST_WRAP;
              end
              default: ;  // action three: take the beat, no result
            endcase
          end
        end
        ST_WRAP: begin
          // bring the angle into -180..180
          if (ang > bcrt_pkg::DEG_180) begin
            ang <= ang - bcrt_pkg::DEG_360;
          end else if (ang < -bcrt_pkg::DEG_180) begin
            ang <= ang + bcrt_pkg::DEG_360;
          end
          state <= ST_FOLD;
        end
        ST_FOLD: begin
          // fold into -90..90; a fold negates sin and cos at the end
          flip <= (ang > bcrt_pkg::DEG_90) || (ang < -bcrt_pkg::DEG_90);
          if (ang > bcrt_pkg::DEG_90) begin
            ang <= ang - bcrt_pkg::DEG_180;
          end else if (ang < -bcrt_pkg::DEG_90) begin
            ang <= ang + bcrt_pkg::DEG_180;
          end
          state <= ST_MAG;
        end
        ST_MAG: begin
          ang_neg <= ang[26];
          ang_mag <= ang[26] ? 24'(-ang) : 24'(ang);
          state   <= ST_MULZ;
        end
        ST_MULZ: begin
          state <= ST_ZLOAD;
        end
        ST_ZLOAD: begin
          // degrees times pi/180, Q32 scale dropped to Q30 radians
          cz    <= ang_neg ? -z_pos : z_pos;
          cx    <= bcrt_pkg::CORDIC_GAIN_Q30;
          cy    <= '0;
          step  <= '0;
          state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - bcrt_pkg::atan_q30(5'(step));
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + bcrt_pkg::atan_q30(5'(step));
          end
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= ST_SIGN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SIGN: begin
          sin_q <= flip ? 32'(-cy) : 32'(cy);
          cos_q <= flip ? 32'(-cx) : 32'(cx);
          k     <= '0;
          phase <= PH_CX;
          state <= ST_ROT;
        end
        ST_ROT: begin
          case (phase)
            PH_SY: acc <= prod_sh;
            PH_SX: new_x <= bcrt_pkg::sat32(35'(acc) - 35'(prod_sh));
            PH_CY: acc <= prod_sh;
            PH_WR: begin
              ox[k] <= new_x;
              oy[k] <= bcrt_pkg::sat32(35'(acc) + 35'(prod_sh));
            end
            default: ;
          endcase
          if (phase == PH_WR) begin
            phase <= PH_CX;
            k     <= k + 1'b1;
            if (k == bcrt_pkg::CORNER_W'(CN - 1)) begin
              state <= ST_EMIT;
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ST_EMIT: begin
          // advance one corner whenever the output register is free
          if (out_free) begin
            k <= k + 1'b1;
            if (k == bcrt_pkg::CORNER_W'(CN - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output payload: centre plus offset, saturated
  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata[31:0]  <= bcrt_pkg::sat32(35'(cen_x) + 35'(ox[k]));
      m_tdata[63:32] <= bcrt_pkg::sat32(35'(cen_y) + 35'(oy[k]));
      m_tdata[95:64] <= bcrt_pkg::sat32(35'(cen_z) + 35'(oz[k]));
      m_tuser        <= k;
      m_tlast        <= (k == bcrt_pkg::CORNER_W'(CN - 1));
    end
  end

endmodule

[rtl/bcrt_checker.sv]
// Port-level checker for the box corner rotate and translate unit, with the
// bind that attaches it to the top level.
// Depends on bcrt_pkg.
module bcrt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bcrt_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bcrt_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [bcrt_pkg::M_TUSER_W-1:0] m_tuser,
  input logic                           m_tlast
);

  // the last beat of a run always carries the final corner index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == bcrt_pkg::M_TUSER_W'(bcrt_pkg::CORNER_COUNT - 1)))
    else $error("last beat without final corner index");

  // reset drops any pending output beat
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an ignored action leaves the block ready
  a_ignore: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == bcrt_pkg::ACT_NONE)) |=> s_tready)
    else $error("ignored action blocked the input");

  // a rebuild or move goes straight to corner output, input closed meanwhile
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     ((s_tuser == bcrt_pkg::ACT_REBUILD) || (s_tuser == bcrt_pkg::ACT_MOVE)))
    |=> !s_tready)
    else $error("input open while an action is in hand");

  // a stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output beat changed");

endmodule

bind box_corner_rotate_translate_unit bcrt_checker u_bcrt_checker (.*);

[tb/box_corner_rotate_translate_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for box_corner_rotate_translate_unit: random and directed
// actions, a bit-exact corner predictor and a scoreboard. Depends on bcrt_pkg and the DUT.
module box_corner_rotate_translate_unit_test;

  localparam int  HALF_PERIOD    = 10;
  localparam int  RESET_CYCLES   = 11;
  localparam int  WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is declared hung
  localparam int  SETTLE_CYCLES  = 100;   // lets the block go idle before the registers are touched
  localparam int  HOLD_AT        = 30;    // actions accepted before the long output stall
  localparam int  HOLD_CYCLES    = 400;
  localparam int  CORDIC_ITERS   = 16;
  localparam int  MAX_REPORTS    = 10;

  // Q9.16 degree constants and Q2.30 / Q0.32 fixed-point factors
  localparam longint ANG_90    = 64'sd5898240;
  localparam longint ANG_180   = 64'sd11796480;
  localparam longint ANG_360   = 64'sd23592960;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint RAD_Q32   = 64'sd74961321;
  localparam longint COORD_MAX = 64'sh7fff_ffff;
  localparam longint COORD_MIN = -64'sh8000_0000;

  // atan(2^-i) in radians, Q2.30
  localparam longint ARCTAN_Q30 [CORDIC_ITERS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767
  };

  // per corner: bit0 X positive, bit1 Y positive, bit2 Z positive
  localparam logic [2:0] CORNER_SIGNS [bcrt_pkg::CORNER_COUNT] = '{
    3'b000, 3'b010, 3'b011, 3'b001, 3'b100, 3'b110, 3'b111, 3'b101
  };

  // angles worth hitting often: zero, the fold and wrap boundaries, full turns
  localparam int EDGE_ANGLES [10] = '{
    0, 5898240, -5898240, 11796480, -11796480, 23592960, -23592960,
    5898241, -11796481, 1
  };

  typedef struct {
    logic [1:0]         action;
    logic [31:0]        pos_x, pos_y, pos_z;
    logic signed [25:0] turn;
  } action_beat_t;

  typedef struct {
    logic [2:0]  index;
    logic [31:0] x, y, z;
    logic        last;
  } corner_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bcrt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic [bcrt_pkg::S_TUSER_W-1:0] s_tuser  = bcrt_pkg::ACT_REBUILD;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bcrt_pkg::M_TDATA_W-1:0] m_tdata;
  logic [bcrt_pkg::M_TUSER_W-1:0] m_tuser;
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bcrt_pkg::CFG_IDX_W-1:0] cfg_index = bcrt_pkg::REG_BOX_LENGTH;
  logic [bcrt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  box_corner_rotate_translate_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor copy of the registers and the box
  logic [30:0]        box_len, box_wid, box_hgt;
  logic signed [31:0] start_cx, start_cy, start_cz;
  logic signed [31:0] centre [3];
  logic signed [31:0] offset [3*bcrt_pkg::CORNER_COUNT];

  action_beat_t action_backlog [$];
  corner_beat_t corners_due [$];
  action_beat_t offered;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int actions_taken  = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  initial begin
    box_len  = '0;
    box_wid  = '0;
    box_hgt  = '0;
    start_cx = '0;
    start_cy = '0;
    start_cz = '0;
    for (int i = 0; i < 3; i++) centre[i] = '0;
    for (int i = 0; i < 3*bcrt_pkg::CORNER_COUNT; i++) offset[i] = '0;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > COORD_MAX) return 32'sh7fff_ffff;
    if (v < COORD_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // sine and cosine, Q2.30, of a Q9.16 degree angle
  task automatic turn_sin_cos(input longint ang, output longint sin_q30,
                              output longint cos_q30);
    longint a, mag, z, x, y, dx, dy;
    bit     flip;
    int     i;
    a    = ang;
    flip = 1'b0;
    // wrap once into -180..180, then fold into -90..90
    if (a > ANG_180) a -= ANG_360;
    if (a < -ANG_180) a += ANG_360;
    if (a > ANG_90) begin
      a -= ANG_180;
      flip = 1'b1;
    end else if (a < -ANG_90) begin
      a += ANG_180;
      flip = 1'b1;
    end
    mag = (a < 0) ? -a : a;
    z   = (mag * RAD_Q32) >>> 18;
    if (a < 0) z = -z;
    x = GAIN_Q30;
    y = 0;
    for (i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sin_q30 = y;
    cos_q30 = x;
  endtask

  // apply one accepted action to the box and queue the eight corners it emits
  task automatic play_action(input action_beat_t b);
    longint       hx, hy, hz, s, c, x, y;
    logic [2:0]   sg;
    corner_beat_t cb;
    int           k;
    case (b.action)
      bcrt_pkg::ACT_REBUILD: begin
        hx = box_len[30:1];
        hy = box_wid[30:1];
        hz = box_hgt[30:1];
        for (k = 0; k < bcrt_pkg::CORNER_COUNT; k++) begin
          sg = CORNER_SIGNS[k];
          offset[3*k]   = sg[0] ? hx : -hx;
          offset[3*k+1] = sg[1] ? hy : -hy;
          offset[3*k+2] = sg[2] ? hz : -hz;
        end
        centre[0] = start_cx;
        centre[1] = start_cy;
        centre[2] = start_cz;
      end
      bcrt_pkg::ACT_MOVE: begin
        centre[0] = b.pos_x;
        centre[1] = b.pos_y;
        centre[2] = b.pos_z;
      end
      bcrt_pkg::ACT_ROTATE: begin
        turn_sin_cos(longint'(b.turn), s, c);
        for (k = 0; k < bcrt_pkg::CORNER_COUNT; k++) begin
          x = offset[3*k];
          y = offset[3*k+1];
          offset[3*k]   = clamp32(((c * x) >>> 30) - ((s * y) >>> 30));
          offset[3*k+1] = clamp32(((s * x) >>> 30) + ((c * y) >>> 30));
        end
      end
      default: return;  // no-op action: no state change, no corners
    endcase
    for (k = 0; k < bcrt_pkg::CORNER_COUNT; k++) begin
      cb.index = k[2:0];
      cb.x     = clamp32(longint'(centre[0]) + longint'(offset[3*k]));
      cb.y     = clamp32(longint'(centre[1]) + longint'(offset[3*k+1]));
      cb.z     = clamp32(longint'(centre[2]) + longint'(offset[3*k+2]));
      cb.last  = (k == bcrt_pkg::CORNER_COUNT - 1);
      corners_due.push_back(cb);
    end
  endtask

  // Driver: offer the next pending action, hold it until it is taken,
  // and predict its corners on the beat that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        play_action(offered);
        actions_taken++;
      end
      if (action_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        offered = action_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, offered.turn, offered.pos_z, offered.pos_y, offered.pos_x};
        s_tuser  <= offered.action;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each corner beat against the oldest prediction, then pick
  // the next ready level. One long hold-off lets the block back up into its input.
  always @(posedge clk) begin
    corner_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (corners_due.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected corner beat: idx %0d x %h y %h z %h last %b",
                     m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
          errors++;
        end else begin
          want = corners_due.pop_front();
          if (m_tuser !== want.index || m_tdata[31:0] !== want.x ||
              m_tdata[63:32] !== want.y || m_tdata[95:64] !== want.z ||
              m_tlast !== want.last) begin
            if (errors < MAX_REPORTS) begin
              $display("corner mismatch: expected idx %0d x %h y %h z %h last %b",
                       want.index, want.x, want.y, want.z, want.last);
              $display("                 actual   idx %0d x %h y %h z %h last %b",
                       m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast);
            end
            errors++;
          end
        end
      end
      if (!hold_done && actions_taken >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; call right after a rising edge. Leaves cfg_valid high
  // so back-to-back writes need no extra assignment in the same step.
  task automatic write_reg(input logic [bcrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bcrt_pkg::REG_BOX_LENGTH: box_len  = val[30:0];
      bcrt_pkg::REG_BOX_WIDTH:  box_wid  = val[30:0];
      bcrt_pkg::REG_BOX_HEIGHT: box_hgt  = val[30:0];
      bcrt_pkg::REG_CENTRE_X:   start_cx = val;
      bcrt_pkg::REG_CENTRE_Y:   start_cy = val;
      bcrt_pkg::REG_CENTRE_Z:   start_cz = val;
      default: ;
    endcase
  endtask

  task automatic program_box(input logic [31:0] len, wid, hgt, cx, cy, cz);
    write_reg(bcrt_pkg::REG_BOX_LENGTH, len);
    write_reg(bcrt_pkg::REG_BOX_WIDTH,  wid);
    write_reg(bcrt_pkg::REG_BOX_HEIGHT, hgt);
    write_reg(bcrt_pkg::REG_CENTRE_X,   cx);
    write_reg(bcrt_pkg::REG_CENTRE_Y,   cy);
    write_reg(bcrt_pkg::REG_CENTRE_Z,   cz);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_action(input logic [1:0] act, input logic [31:0] px, py, pz,
                                      input int ang);
    action_beat_t b;
    b.action = act;
    b.pos_x  = px;
    b.pos_y  = py;
    b.pos_z  = pz;
    b.turn   = ang[25:0];
    action_backlog.push_back(b);
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int random_angle();
    if ($urandom_range(4) == 0) return EDGE_ANGLES[$urandom_range(9)];
    return int'($urandom_range(2 * 23592960)) - 23592960;
  endfunction

  // Queue random actions, mostly real work with a sprinkling of no-ops;
  // only real actions count toward the total.
  task automatic queue_random(input int count);
    int done, pick;
    logic [1:0] act;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 6)       act = bcrt_pkg::ACT_NONE;
      else if (pick < 28) act = bcrt_pkg::ACT_REBUILD;
      else if (pick < 55) act = bcrt_pkg::ACT_MOVE;
      else                act = bcrt_pkg::ACT_ROTATE;
      push_action(act, random_coord(), random_coord(), random_coord(), random_angle());
      if (act != bcrt_pkg::ACT_NONE) done++;
    end
  endtask

  // Wait for every action to be taken and every corner to come back, then let
  // any no-op still inside the block drain before the registers are touched.
  task automatic drain();
    while (action_backlog.size() != 0 || s_tvalid || corners_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: widest odd box off centre, every fold and wrap boundary,
    // saturating moves and the no-op action
    send_gap_pct   = 38;
    recv_stall_pct = 82;
    program_box(32'h7fff_ffff, 32'h0003_0001, 32'h0001_2345,
                32'h4000_0000, 32'hc000_0000, 32'h0000_0007);
    push_action(bcrt_pkg::ACT_REBUILD, '0, '0, '0, 0);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 0);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 5898240);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, -5898240);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 11796480);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, -11796480);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 23592960);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, -23592960);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 32'h002d_8000);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 135 * 65536);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, -135 * 65536);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 270 * 65536);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, -270 * 65536);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 1);
    push_action(bcrt_pkg::ACT_NONE, 32'h1234_5678, 32'h9abc_def0, 32'hffff_ffff, -1);
    push_action(bcrt_pkg::ACT_MOVE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    push_action(bcrt_pkg::ACT_MOVE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, 30 * 65536);
    push_action(bcrt_pkg::ACT_MOVE, '0, '0, '0, -1);
    push_action(bcrt_pkg::ACT_REBUILD, 32'hffff_ffff, '0, 32'hffff_ffff, 23592960);
    push_action(bcrt_pkg::ACT_MOVE, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 0);
    push_action(bcrt_pkg::ACT_ROTATE, '0, '0, '0, -1);
    push_action(bcrt_pkg::ACT_NONE, '0, '0, '0, 0);
    drain();

    // random box; the long output hold-off lands in this phase
    program_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(28);
    drain();

    // largest box, centre at the extremes; idling swapped over
    send_gap_pct   = 82;
    recv_stall_pct = 38;
    program_box(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    queue_random(28);
    drain();

    // degenerate box with the most negative centre; no idling at all
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    program_box(32'h0000_0001, 32'h0000_0002, 32'h7fff_fffe,
                32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
    queue_random(28);
    drain();

    errors += corners_due.size();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
